### rtl/core/aes_pkg.sv
// Shared types, S-box and round helpers for the AES-128 encrypt pipeline.
package aes_pkg;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_beat_t;

  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW  = 1'b1;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  // Byte i of a 128-bit word, byte 0 most significant.
  function automatic logic [7:0] byte_of(input logic [127:0] v, input int i);
    byte_of = v[127-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  // One key-schedule step.
  function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t;
    logic [127:0] n;
    t = {SBOX[byte_of(k,13)] ^ rc, SBOX[byte_of(k,14)], SBOX[byte_of(k,15)],
         SBOX[byte_of(k,12)]};
    n[127:96] = k[127:96] ^ t;
    n[95:64]  = k[95:64] ^ n[127:96];
    n[63:32]  = k[63:32] ^ n[95:64];
    n[31:0]   = k[31:0] ^ n[63:32];
    next_key = n;
  endfunction

  // SubBytes, ShiftRows, optional MixColumns.
  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int rr = 0; rr < 4; rr++) begin
        t[4*c+rr] = SBOX[byte_of(s, 4*((c+rr)%4)+rr)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (mix) begin
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = t[i];
    end
    round_fn = r;
  endfunction

endpackage

### rtl/core/aes_round.sv
// One pipelined AES round: state and round key advance together.
module aes_round #(
  parameter logic [7:0] RCON = 8'h01,
  parameter bit         MIX  = 1'b1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         vld_i,
  input  logic [127:0] st_i,
  input  logic [127:0] key_i,
  output logic         vld_o,
  output logic [127:0] st_o,
  output logic [127:0] key_o
);
  logic         vld_r;
  logic [127:0] st_r, key_r;
  logic [127:0] key_nxt;

  assign key_nxt = aes_pkg::next_key(key_i, RCON);

  // Advance valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  // Register round output and next key.
  always_ff @(posedge clk) begin
    st_r  <= aes_pkg::round_fn(st_i, MIX) ^ key_nxt;
    key_r <= key_nxt;
  end

  assign vld_o = vld_r;
  assign st_o  = st_r;
  assign key_o = key_r;
endmodule

### rtl/core/aes128_block_encrypt.sv
// Top level of the AES-128 block encrypt pipeline.
// The valid bit runs from start through the AddRoundKey register, then one register per round, to out_valid.
// Throughput: one block per cycle; busy stays low, one register stage per round.
// Key registers are sampled at entry; write them only while idle.
// Reset (synchronous, rst_n low) clears valid bits and the key to zero.
// The receiver cannot stall: out_valid is a one-cycle strobe.
module aes128_block_encrypt #(
  parameter int NUM_ROUNDS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  aes_pkg::in_beat_t                  in_data,
  output logic                               out_valid,
  output aes_pkg::out_beat_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [aes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [63:0]                        cfg_data
);
  logic [63:0]  key_high_r, key_low_r;
  logic         v0_r;
  logic [127:0] s0_r, k0_r;
  logic         vld [NUM_ROUNDS+1];
  logic [127:0] st  [NUM_ROUNDS+1];
  logic [127:0] ky  [NUM_ROUNDS+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Hold key registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_valid && cfg_index[aes_pkg::CFG_IDX_W-1:1] == '0) begin
      unique case (cfg_index[0])
        aes_pkg::REG_KEY_HIGH: key_high_r <= cfg_data;
        aes_pkg::REG_KEY_LOW:  key_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Initial AddRoundKey stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end
  always_ff @(posedge clk) begin
    s0_r <= {in_data.block_high, in_data.block_low} ^ {key_high_r, key_low_r};
    k0_r <= {key_high_r, key_low_r};
  end

  assign vld[0] = v0_r;
  assign st[0]  = s0_r;
  assign ky[0]  = k0_r;

  // Round stages, round constant built by repeated xtime.
  function automatic logic [7:0] rcon_of(input int n);
    logic [7:0] r;
    r = 8'h01;
    for (int i = 1; i < n; i++) begin
      r = aes_pkg::xtime(r);
    end
    rcon_of = r;
  endfunction

  for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_rnd
    aes_round #(.RCON(rcon_of(g)), .MIX(g != NUM_ROUNDS)) u_rnd (
      .clk(clk), .rst_n(rst_n),
      .vld_i(vld[g-1]), .st_i(st[g-1]), .key_i(ky[g-1]),
      .vld_o(vld[g]), .st_o(st[g]), .key_o(ky[g])
    );
  end

  assign out_valid            = vld[NUM_ROUNDS];
  assign out_data.cipher_high = st[NUM_ROUNDS][127:64];
  assign out_data.cipher_low  = st[NUM_ROUNDS][63:0];
endmodule

### rtl/core/aes_checker.sv
// Port-level checker for the AES-128 encrypt pipeline, bound to the top.
module aes_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_ready
);
  // Each accepted beat gives one out_valid strobe, after the AddRoundKey register and the round registers.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##11 out_valid) else $error("result missing");
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n, 11) && !$past(start, 11) |-> !out_valid) else $error("spurious result");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_cfg: assert property (@(posedge clk) cfg_ready) else $error("cfg stalled");
endmodule

bind aes128_block_encrypt aes_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .cfg_ready(cfg_ready)
);
